[rtl/core/dgr_pkg.sv]
package dgr_pkg;

   localparam int unsigned XW = 4;
   localparam int unsigned YW = 3;
   localparam int unsigned IW = 4;
   localparam int unsigned NW = 5;
   localparam int unsigned DW = 13;

   localparam logic [1:0] OP_PLACE = 2'd0;
   localparam logic [1:0] OP_GOAL  = 2'd1;
   localparam logic [1:0] OP_RUN   = 2'd2;
   localparam logic [1:0] OP_SPARE = 2'd3;

   localparam logic [0:0] CSR_ACTIVE   = 1'b0;
   localparam logic [0:0] CSR_FEEDBACK = 1'b1;

   localparam logic [DW-1:0] FAR_DIST = 13'd6000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COMMIT,
      ST_CHOOSE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic write_place;
      logic write_goal;
      logic clr_idx;
      logic do_commit;
      logic do_choose;
      logic do_emit;
   } cmd_type;

   typedef struct packed {
      logic idx_last;
      logic none;
   } sts_type;

endpackage

[rtl/core/dgr_ctrl.sv]
module dgr_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [1:0]       op,
   input  dgr_pkg::sts_type sts,
   output logic             busy,
   output dgr_pkg::cmd_type cmd
);
   import dgr_pkg::*;

   state_type state_ff, state_in;
   logic      take;

   assign take = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take && op == OP_RUN && !sts.none) state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (sts.idx_last) state_in = ST_CHOOSE;
         end
         ST_CHOOSE: begin
            if (sts.idx_last) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.idx_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy            = 1'b0;
            cmd.load        = take && op == OP_RUN;
            cmd.write_place = take && op == OP_PLACE;
            cmd.write_goal  = take && op == OP_GOAL;
            cmd.clr_idx     = 1'b1;
         end
         ST_COMMIT: begin
            cmd.do_commit = 1'b1;
            cmd.clr_idx   = sts.idx_last;
         end
         ST_CHOOSE: begin
            cmd.do_choose = 1'b1;
            cmd.clr_idx   = sts.idx_last;
         end
         ST_EMIT: cmd.do_emit = 1'b1;
         default: busy = 1'b1;
      endcase
   end
endmodule

[rtl/core/dgr_path.sv]
module dgr_path #(
   parameter int unsigned GRID_W     = 16,
   parameter int unsigned GRID_H     = 8,
   parameter int unsigned DROP_SLOTS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  dgr_pkg::cmd_type         cmd,
   output dgr_pkg::sts_type         sts,
   input  logic [4:0]               active_drops,
   input  logic                     feedback_enable,
   input  logic [3:0]               drop_index,
   input  logic [3:0]               cell_x,
   input  logic [2:0]               cell_y,
   input  logic [63:0]              feedback_low,
   input  logic [63:0]              feedback_high,
   output logic                     out_valid,
   output logic [3:0]               out_drop,
   output logic [3:0]               out_next_x,
   output logic [2:0]               out_next_y,
   output logic                     out_moving,
   output logic                     any_running,
   output logic                     last
);
   import dgr_pkg::*;

   localparam int unsigned SW = (DROP_SLOTS > 1) ? $clog2(DROP_SLOTS) : 1;

   logic [XW-1:0] pos_x_ff [DROP_SLOTS];
   logic [YW-1:0] pos_y_ff [DROP_SLOTS];
   logic [XW-1:0] nxt_x_ff [DROP_SLOTS];
   logic [YW-1:0] nxt_y_ff [DROP_SLOTS];
   logic [XW-1:0] goal_x_ff [DROP_SLOTS];
   logic [YW-1:0] goal_y_ff [DROP_SLOTS];
   logic [DROP_SLOTS-1:0] pend_ff;
   logic [127:0]  map_ff;
   logic [SW-1:0] idx_ff;
   logic [NW-1:0] n_ff;
   logic          any_ff;
   logic [NW-1:0] n_in;
   logic [XW-1:0] cx, px, nx, gx;
   logic [YW-1:0] cy, py, ny, gy;
   logic          idx_ok;
   logic          commit;
   logic          away;
   logic          rt, lt, up, dn;
   logic [DW-1:0] d_rt, d_lt, d_up, d_dn, best1, best2;
   logic          pick_lt, pick_up, pick_dn;

   function automatic logic free_at(logic [127:0] m, int x, int y);
      if (x < 0 || x >= int'(GRID_W) || y < 0 || y >= int'(GRID_H)) return 1'b1;
      return m[{y[2:0], x[3:0]}];
   endfunction

   function automatic logic open_at(logic [127:0] m, int x, int y, int dx, int dy);
      logic ok;
      ok = 1'b1;
      for (int k = -1; k <= 1; k++) begin
         ok = ok & free_at(m, (dx != 0) ? x + dx : x + k, (dy != 0) ? y + dy : y + k);
      end
      return ok;
   endfunction

   function automatic logic [DW-1:0] sqd(int x, int y, int tx, int ty);
      int s;
      s = (x - tx) * (x - tx) + (y - ty) * (y - ty);
      return DW'(s);
   endfunction

   assign n_in   = (active_drops > NW'(DROP_SLOTS)) ? NW'(DROP_SLOTS) : active_drops;
   assign cx     = ({1'b0, cell_x} >= (XW+1)'(GRID_W)) ? XW'(GRID_W - 1) : cell_x;
   assign cy     = ({1'b0, cell_y} >= (YW+1)'(GRID_H)) ? YW'(GRID_H - 1) : cell_y;
   assign idx_ok = {1'b0, drop_index} < (IW+1)'(DROP_SLOTS);

   assign px = pos_x_ff[idx_ff];
   assign py = pos_y_ff[idx_ff];
   assign nx = nxt_x_ff[idx_ff];
   assign ny = nxt_y_ff[idx_ff];
   assign gx = goal_x_ff[idx_ff];
   assign gy = goal_y_ff[idx_ff];

   assign sts.none     = (n_in == '0);
   assign sts.idx_last = (NW'(idx_ff) + NW'(1)) == n_ff;

   assign commit = !feedback_enable ||
                   ((px != nx || py != ny) && map_ff[{py, px}] && !map_ff[{ny, nx}]);

   assign away = (px != gx) || (py != gy);

   always_comb begin
      rt = (int'(px) < int'(GRID_W) - 1) && open_at(map_ff, int'(px) + 1, int'(py), 1, 0);
      lt = (px != '0) && open_at(map_ff, int'(px) - 1, int'(py), -1, 0);
      up = (py != '0) && open_at(map_ff, int'(px), int'(py) - 1, 0, -1);
      dn = (int'(py) < int'(GRID_H) - 1) && open_at(map_ff, int'(px), int'(py) + 1, 0, 1);
      d_rt = sqd(int'(px) + 1, int'(py), int'(gx), int'(gy));
      d_lt = sqd(int'(px) - 1, int'(py), int'(gx), int'(gy));
      d_up = sqd(int'(px), int'(py) - 1, int'(gx), int'(gy));
      d_dn = sqd(int'(px), int'(py) + 1, int'(gx), int'(gy));
      best1   = rt ? d_rt : FAR_DIST;
      pick_lt = lt && (d_lt < best1);
      best1   = pick_lt ? d_lt : best1;
      pick_up = up && (d_up < best1);
      best2   = pick_up ? d_up : best1;
      pick_dn = dn && (d_dn < best2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         idx_ff  <= '0;
         n_ff    <= '0;
         any_ff  <= 1'b0;
         for (int i = 0; i < int'(DROP_SLOTS); i++) begin
            pos_x_ff[i] <= '0; pos_y_ff[i] <= '0;
            nxt_x_ff[i] <= '0; nxt_y_ff[i] <= '0;
            goal_x_ff[i] <= '0; goal_y_ff[i] <= '0;
         end
      end else begin
         if (cmd.clr_idx) idx_ff <= '0;
         else idx_ff <= idx_ff + SW'(1);
         if (cmd.write_place && idx_ok) begin
            pos_x_ff[drop_index[SW-1:0]] <= cx;
            pos_y_ff[drop_index[SW-1:0]] <= cy;
            nxt_x_ff[drop_index[SW-1:0]] <= cx;
            nxt_y_ff[drop_index[SW-1:0]] <= cy;
            pend_ff[drop_index[SW-1:0]]  <= 1'b0;
         end
         if (cmd.write_goal && idx_ok) begin
            goal_x_ff[drop_index[SW-1:0]] <= cx;
            goal_y_ff[drop_index[SW-1:0]] <= cy;
         end
         if (cmd.load) begin
            map_ff <= {feedback_high, feedback_low};
            n_ff   <= n_in;
            any_ff <= 1'b0;
         end
         if (cmd.do_commit && commit) begin
            pos_x_ff[idx_ff] <= nx;
            pos_y_ff[idx_ff] <= ny;
            pend_ff[idx_ff]  <= 1'b0;
         end
         if (cmd.do_choose) begin
            any_ff <= any_ff | away;
            if (away && !pend_ff[idx_ff]) begin
               priority if (pick_dn) begin
                  nxt_y_ff[idx_ff] <= py + YW'(1); nxt_x_ff[idx_ff] <= px;
                  pend_ff[idx_ff] <= 1'b1;
               end else if (pick_up) begin
                  nxt_y_ff[idx_ff] <= py - YW'(1); nxt_x_ff[idx_ff] <= px;
                  pend_ff[idx_ff] <= 1'b1;
               end else if (pick_lt) begin
                  nxt_x_ff[idx_ff] <= px - XW'(1); nxt_y_ff[idx_ff] <= py;
                  pend_ff[idx_ff] <= 1'b1;
               end else if (rt) begin
                  nxt_x_ff[idx_ff] <= px + XW'(1); nxt_y_ff[idx_ff] <= py;
                  pend_ff[idx_ff] <= 1'b1;
               end
            end
         end
      end
   end

   assign out_valid   = cmd.do_emit;
   assign out_drop    = IW'(idx_ff);
   assign out_next_x  = nx;
   assign out_next_y  = ny;
   assign out_moving  = pend_ff[idx_ff];
   assign any_running = any_ff;
   assign last        = sts.idx_last;
endmodule

[rtl/core/droplet_grid_router_step.sv]
// Droplet router for a GRID_W x GRID_H electrode grid. A transaction is taken
// when start is high and busy is low. Place and goal transactions give no
// result. A run transaction for N active droplets (at most DROP_SLOTS, 16 by
// default) has a sequencer walk the droplet table once to commit moves, once
// to choose steps, and once to emit results, one droplet per cycle.
// Results appear on rsp_ ports for one cycle each, flagged by rsp_valid, in
// droplet order with rsp_last on the final one; the receiver cannot stall.
module droplet_grid_router_step #(
   parameter int unsigned GRID_W     = 16,
   parameter int unsigned GRID_H     = 8,
   parameter int unsigned DROP_SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_op,
   input  logic [3:0]  req_drop_index,
   input  logic [3:0]  req_cell_x,
   input  logic [2:0]  req_cell_y,
   input  logic [63:0] req_feedback_low,
   input  logic [63:0] req_feedback_high,
   output logic        rsp_valid,
   output logic [3:0]  rsp_out_drop,
   output logic [3:0]  rsp_out_next_x,
   output logic [2:0]  rsp_out_next_y,
   output logic        rsp_out_moving,
   output logic        rsp_any_running,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [4:0]  csr_wdata
);
   import dgr_pkg::*;

   cmd_type    cmd;
   sts_type    sts;
   logic [4:0] active_ff;
   logic       fb_ff;

   // Hold configuration; the user must write it only while idle (not enforced here).
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         fb_ff     <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ACTIVE:   active_ff <= csr_wdata;
            CSR_FEEDBACK: fb_ff     <= csr_wdata[0];
            default:      fb_ff     <= fb_ff;
         endcase
      end
   end

   dgr_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .op    (req_op),
      .sts   (sts),
      .busy  (busy),
      .cmd   (cmd)
   );

   dgr_path #(
      .GRID_W     (GRID_W),
      .GRID_H     (GRID_H),
      .DROP_SLOTS (DROP_SLOTS)
   ) u_path (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .active_drops    (active_ff),
      .feedback_enable (fb_ff),
      .drop_index      (req_drop_index),
      .cell_x          (req_cell_x),
      .cell_y          (req_cell_y),
      .feedback_low    (req_feedback_low),
      .feedback_high   (req_feedback_high),
      .out_valid       (rsp_valid),
      .out_drop        (rsp_out_drop),
      .out_next_x      (rsp_out_next_x),
      .out_next_y      (rsp_out_next_y),
      .out_moving      (rsp_out_moving),
      .any_running     (rsp_any_running),
      .last            (rsp_last)
   );
endmodule
